@@ sv/srec_pkg.sv @@
// Shared types, codes and helpers for the S-record line encoder.
package srec_pkg;

   // Default number of data bytes held before a line is forced out
   localparam int RecordBytesDefault = 16;

   // Input operation codes
   typedef enum logic [1:0] {
      OP_START  = 2'd0,
      OP_DATA   = 2'd1,
      OP_LAST   = 2'd2,
      OP_FINISH = 2'd3
   } op_type;

   // Record type register codes (address width)
   localparam logic [1:0] TypeS1 = 2'd0;
   localparam logic [1:0] TypeS2 = 2'd1;
   localparam logic [1:0] TypeS3 = 2'd2;
   localparam logic [1:0] TypeUnused = 2'd3;

   // Register indexes
   localparam logic [0:0] RegRecordType  = 1'b0;
   localparam logic [0:0] RegBaseAddress = 1'b1;

   // ASCII characters
   localparam logic [7:0] CharS    = 8'h53;
   localparam logic [7:0] Char0    = 8'h30;
   localparam logic [7:0] Char1    = 8'h31;
   localparam logic [7:0] Char9    = 8'h39;
   localparam logic [7:0] CharUpA  = 8'h41;
   localparam logic [7:0] CharCr   = 8'h0D;
   localparam logic [7:0] CharLf   = 8'h0A;

   // Line sequencer phases
   typedef enum logic [3:0] {
      PH_IDLE,
      PH_S,
      PH_TYPE,
      PH_COUNT,
      PH_ADDR,
      PH_DATA,
      PH_CSUM,
      PH_CR,
      PH_LF
   } phase_type;

   // One nibble to an upper-case hex digit
   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] res;
      if (nib < 4'd10) begin
         res = Char0 + {4'h0, nib};
      end else begin
         res = CharUpA + {4'h0, nib} - 8'd10;
      end
      return res;
   endfunction

endpackage

@@ sv/srec_line_encoder_core.sv @@
// S-record line encoder: byte buffer, line sequencer and character output register.
//
//  channel | ports                                    | direction
//  --------+------------------------------------------+----------
//  req     | req_valid/ready, operation, data_byte   | in
//  rsp     | rsp_valid/ready, character, line_end    | out
//  csr     | csr_we, csr_index, csr_wdata            | in
//
// A start, or a data byte that does not close a record, starts no line and leaves req_ready high.
// A closing byte or a finish starts a line of 2*N + 2*A + 8 characters
// (N data bytes, A = 2, 3 or 4 address bytes), one per unstalled cycle through the
// single character output register; the line sequencer holds req_ready low
// until the LF is loaded. rsp_ready low stalls the sequencer in place.
// Reset is synchronous; no clearing pass is needed after it.
module srec_line_encoder_core #(
   parameter int RECORD_BYTES = srec_pkg::RecordBytesDefault
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_data_byte,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_character,
   output logic        rsp_line_end,
   // configuration
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int CntW = ($clog2(RECORD_BYTES + 1) > 3) ? $clog2(RECORD_BYTES + 1) : 3;
   localparam int IdxW = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;

   // configuration registers
   logic [1:0]             record_type_ff;
   logic [31:0]            base_address_ff;

   // buffer and record state
   logic [7:0]             buf_ff [RECORD_BYTES];
   logic [CntW-1:0]        count_ff;
   logic [31:0]            running_ff;

   // line sequencer
   srec_pkg::phase_type    phase_ff, phase_in;
   logic                   nib_hi_ff, nib_hi_in;
   logic [CntW-1:0]        cnt_ff, cnt_in;
   logic [CntW-1:0]        ndata_ff;
   logic                   term_ff;
   logic [31:0]            addr_sh_ff;
   logic [7:0]             sum_ff;

   // output register
   logic                   rsp_valid_ff;
   logic [7:0]             rsp_character_ff;
   logic                   rsp_line_end_ff;

   logic                   req_fire;
   logic                   is_data;
   logic                   line_start;
   logic [CntW-1:0]        count_next;
   logic [1:0]             type_idx;
   logic                   emit_go;
   logic [7:0]             count_byte;
   logic [7:0]             cur_byte;
   logic [3:0]             cur_nib;
   logic [7:0]             cur_char;
   logic [31:0]            line_addr;
   logic [31:0]            aligned_addr;

   assign req_ready     = (phase_ff == srec_pkg::PH_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_line_end  = rsp_line_end_ff;

   // request decode
   assign req_fire   = req_valid && req_ready;
   assign is_data    = (req_operation == srec_pkg::OP_DATA) ||
                       (req_operation == srec_pkg::OP_LAST);
   assign count_next = count_ff + CntW'(1);
   assign line_start = req_fire &&
                       ((req_operation == srec_pkg::OP_FINISH) ||
                        (is_data && ((req_operation == srec_pkg::OP_LAST) ||
                                     (count_next == CntW'(RECORD_BYTES)))));

   // unused type code falls back to S1
   assign type_idx   = (record_type_ff == srec_pkg::TypeUnused) ? srec_pkg::TypeS1
                                                                : record_type_ff;
   assign emit_go    = (phase_ff != srec_pkg::PH_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign count_byte = 8'(ndata_ff) + {6'h0, type_idx} + 8'd3;

   // left-align the printed address bytes
   assign line_addr = (req_operation == srec_pkg::OP_FINISH) ? 32'h0 : running_ff;
   always_comb begin
      case (type_idx)
         srec_pkg::TypeS1: aligned_addr = {line_addr[15:0], 16'h0};
         srec_pkg::TypeS2: aligned_addr = {line_addr[23:0], 8'h0};
         default:          aligned_addr = line_addr;
      endcase
   end

   // sequencer next state
   always_comb begin
      phase_in  = phase_ff;
      nib_hi_in = nib_hi_ff;
      cnt_in    = cnt_ff;
      if (phase_ff == srec_pkg::PH_IDLE) begin
         if (line_start) begin
            phase_in  = srec_pkg::PH_S;
            nib_hi_in = 1'b1;
         end
      end else if (emit_go) begin
         case (phase_ff)
            srec_pkg::PH_S: begin
               phase_in = srec_pkg::PH_TYPE;
            end
            srec_pkg::PH_TYPE: begin
               phase_in  = srec_pkg::PH_COUNT;
               nib_hi_in = 1'b1;
            end
            srec_pkg::PH_COUNT: begin
               nib_hi_in = !nib_hi_ff;
               if (!nib_hi_ff) begin
                  phase_in = srec_pkg::PH_ADDR;
                  cnt_in   = CntW'(type_idx) + CntW'(1);
               end
            end
            srec_pkg::PH_ADDR: begin
               nib_hi_in = !nib_hi_ff;
               if (!nib_hi_ff) begin
                  if (cnt_ff != '0) begin
                     cnt_in = cnt_ff - CntW'(1);
                  end else if (ndata_ff == '0) begin
                     phase_in = srec_pkg::PH_CSUM;
                  end else begin
                     phase_in = srec_pkg::PH_DATA;
                     cnt_in   = '0;
                  end
               end
            end
            srec_pkg::PH_DATA: begin
               nib_hi_in = !nib_hi_ff;
               if (!nib_hi_ff) begin
                  cnt_in = cnt_ff + CntW'(1);
                  if (cnt_ff + CntW'(1) == ndata_ff) begin
                     phase_in = srec_pkg::PH_CSUM;
                  end
               end
            end
            srec_pkg::PH_CSUM: begin
               nib_hi_in = !nib_hi_ff;
               if (!nib_hi_ff) begin
                  phase_in = srec_pkg::PH_CR;
               end
            end
            srec_pkg::PH_CR: begin
               phase_in = srec_pkg::PH_LF;
            end
            srec_pkg::PH_LF: begin
               phase_in = srec_pkg::PH_IDLE;
            end
            default: begin
               phase_in = srec_pkg::PH_IDLE;
            end
         endcase
      end
   end

   // character for the current phase
   always_comb begin
      case (phase_ff)
         srec_pkg::PH_COUNT: cur_byte = count_byte;
         srec_pkg::PH_ADDR:  cur_byte = addr_sh_ff[31:24];
         srec_pkg::PH_DATA:  cur_byte = buf_ff[cnt_ff[IdxW-1:0]];
         srec_pkg::PH_CSUM:  cur_byte = ~sum_ff;
         default:            cur_byte = 8'h00;
      endcase
      cur_nib = nib_hi_ff ? cur_byte[7:4] : cur_byte[3:0];
      case (phase_ff)
         srec_pkg::PH_S:     cur_char = srec_pkg::CharS;
         srec_pkg::PH_TYPE:  cur_char = term_ff ? (srec_pkg::Char9 - {6'h0, type_idx})
                                                : (srec_pkg::Char1 + {6'h0, type_idx});
         srec_pkg::PH_COUNT,
         srec_pkg::PH_ADDR,
         srec_pkg::PH_DATA,
         srec_pkg::PH_CSUM:  cur_char = srec_pkg::hex_char(cur_nib);
         srec_pkg::PH_CR:    cur_char = srec_pkg::CharCr;
         srec_pkg::PH_LF:    cur_char = srec_pkg::CharLf;
         default:            cur_char = 8'h00;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= srec_pkg::PH_IDLE;
         nib_hi_ff       <= 1'b1;
         cnt_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
         count_ff        <= '0;
         running_ff      <= 32'h0;
         record_type_ff  <= srec_pkg::TypeS1;
         base_address_ff <= 32'h0;
      end else begin
         phase_ff  <= phase_in;
         nib_hi_ff <= nib_hi_in;
         cnt_ff    <= cnt_in;

         // output slot: load on emit, free on transfer
         if (emit_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         // buffered count and running address
         if (req_fire) begin
            if (req_operation == srec_pkg::OP_START) begin
               running_ff <= base_address_ff;
               count_ff   <= '0;
            end else if (line_start) begin
               count_ff <= '0;
               if (is_data) begin
                  running_ff <= running_ff + 32'(count_next);
               end
            end else begin
               count_ff <= count_next;
            end
         end

         // configuration writes
         if (csr_we) begin
            case (csr_index)
               srec_pkg::RegRecordType:  record_type_ff  <= csr_wdata[1:0];
               srec_pkg::RegBaseAddress: base_address_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire && is_data) begin
         buf_ff[count_ff[IdxW-1:0]] <= req_data_byte;
      end

      if (emit_go) begin
         rsp_character_ff <= cur_char;
         rsp_line_end_ff  <= (phase_ff == srec_pkg::PH_LF);
      end

      // latch line context; checksum adder runs on each high nibble of count, address and data
      if (line_start) begin
         term_ff    <= (req_operation == srec_pkg::OP_FINISH);
         ndata_ff   <= is_data ? count_next : '0;
         addr_sh_ff <= aligned_addr;
         sum_ff     <= 8'h00;
      end else if (emit_go) begin
         if (nib_hi_ff && ((phase_ff == srec_pkg::PH_COUNT) ||
                           (phase_ff == srec_pkg::PH_ADDR) ||
                           (phase_ff == srec_pkg::PH_DATA))) begin
            sum_ff <= sum_ff + cur_byte;
         end
         if (!nib_hi_ff && (phase_ff == srec_pkg::PH_ADDR)) begin
            addr_sh_ff <= {addr_sh_ff[23:0], 8'h00};
         end
      end
   end

   // buffer never holds a full record while waiting for input
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff < CntW'(RECORD_BYTES))
      else $error("buffered count reached record size while idle");

   // a line always begins with S after the previous LF
   a_s_after_lf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_line_end |=> !rsp_valid || rsp_character == srec_pkg::CharS)
      else $error("line did not start with S");

   // line end marks exactly the LF character
   a_line_end_lf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_line_end |-> rsp_character == srec_pkg::CharLf)
      else $error("line end flagged on a character other than LF");

   // no new line starts while a line is still being sequenced
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      phase_ff != srec_pkg::PH_IDLE |-> !req_fire)
      else $error("request taken during line output");

endmodule

@@ tb/srec_line_encoder_checker.sv @@
// Checker for the S-record line encoder: predicts every output line and compares it.
module srec_line_encoder_checker
   import srec_pkg::*;
#(
   parameter int RECORD_BYTES = RecordBytesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_data_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_character,
   input  logic        rsp_line_end,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output int          fail_count,
   output int          pending_count,
   output int          char_count,
   output int          line_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] ch;
      logic       eol;
   } line_char_type;

   // characters still owed by the block, oldest first
   line_char_type  line_chars[$];

   // shadow of the registers and the encoder state
   logic [1:0]  cfg_type;
   logic [31:0] cfg_base;
   logic [7:0]  rec_bytes [RECORD_BYTES];
   int unsigned fill;
   logic [31:0] run_addr;
   logic [7:0]  data_sum;

   function automatic logic [7:0] nibble_ascii(input logic [3:0] n);
      return (n > 4'd9) ? CharUpA - 8'd10 + 8'(n) : Char0 + 8'(n);
   endfunction

   function automatic void put_char(input logic [7:0] c, input logic e);
      line_chars.insert(line_chars.size(), '{ch: c, eol: e});
   endfunction

   function automatic void put_hex(input logic [7:0] b);
      put_char(nibble_ascii(b[7:4]), 1'b0);
      put_char(nibble_ascii(b[3:0]), 1'b0);
   endfunction

   // One full line; a terminator carries address zero and no data
   function automatic void emit_line(input logic term);
      logic [1:0]  t;
      int unsigned abytes;
      int unsigned ndata;
      logic [31:0] addr;
      logic [7:0]  cnt;
      logic [7:0]  sum;
      logic [7:0]  b;
      t      = (cfg_type == TypeUnused) ? TypeS1 : cfg_type;
      abytes = 2 + t;
      ndata  = term ? 0 : fill;
      addr   = term ? 32'h0 : run_addr;
      cnt    = 8'(ndata + abytes + 1);
      sum    = cnt + (term ? 8'd0 : data_sum);
      put_char(CharS, 1'b0);
      put_char(term ? Char9 - 8'(t) : Char1 + 8'(t), 1'b0);
      put_hex(cnt);
      // address field is truncated to its width, most significant byte first
      for (int i = abytes; i > 0; i--) begin
         b = addr[8*(i-1) +: 8];
         sum += b;
         put_hex(b);
      end
      for (int unsigned i = 0; i < ndata; i++) begin
         put_hex(rec_bytes[i]);
      end
      put_hex(8'hFF - sum);
      put_char(CharCr, 1'b0);
      put_char(CharLf, 1'b1);
   endfunction

   function automatic void encode_item(input op_type op, input logic [7:0] d);
      case (op)
         OP_START: begin
            run_addr = cfg_base;
            fill     = 0;
            data_sum = 8'h00;
         end
         OP_FINISH: begin
            // pending bytes are dropped, only the terminator goes out
            fill     = 0;
            data_sum = 8'h00;
            emit_line(1'b1);
         end
         default: begin
            if (fill < RECORD_BYTES) begin
               rec_bytes[fill] = d;
               fill++;
               data_sum += d;
            end
            if (op == OP_LAST || fill >= RECORD_BYTES) begin
               emit_line(1'b0);
               run_addr += 32'(fill);
               fill     = 0;
               data_sum = 8'h00;
            end
         end
      endcase
   endfunction

   // Sample every transfer at the rising edge
   always @(posedge clock) begin
      line_char_type want;
      line_char_type got;
      if (reset) begin
         line_chars.delete();
         cfg_type      = TypeS1;
         cfg_base      = 32'h0;
         fill          = 0;
         run_addr      = 32'h0;
         data_sum      = 8'h00;
         fail_count    = 0;
         char_count    = 0;
         line_count    = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               RegRecordType:  cfg_type = csr_wdata[1:0];
               RegBaseAddress: cfg_base = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            encode_item(op_type'(req_operation), req_data_byte);
         end
         if (rsp_valid && rsp_ready) begin
            got = '{ch: rsp_character, eol: rsp_line_end};
            if (line_chars.size() == 0) begin
               if (fail_count < 10) begin
                  $display("%0t: unexpected character %h line_end %b", $realtime,
                           got.ch, got.eol);
               end
               fail_count++;
            end else begin
               want = line_chars.pop_front();
               char_count++;
               if (want.eol) begin
                  line_count++;
               end
               if (want.ch !== got.ch || want.eol !== got.eol) begin
                  if (fail_count < 10) begin
                     $display("%0t: mismatch character exp %h got %h,",
                              $realtime, want.ch, got.ch,
                              " line_end exp %b got %b", want.eol, got.eol);
                  end
                  fail_count++;
               end
            end
         end
      end
      pending_count = line_chars.size();
   end

endmodule

@@ tb/tb_srec_line_encoder_core.sv @@
// Testbench top for the S-record line encoder: clock, reset, stimulus and verdict.
module tb_srec_line_encoder_core;
   timeunit 1ns;
   timeprecision 1ps;
   import srec_pkg::*;

   localparam int CycleLimit  = 200_000;
   localparam int RandomItems = 95;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_operation;
   logic [7:0]  req_data_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_character;
   logic        rsp_line_end;
   logic        csr_we;
   logic [0:0]  csr_index;
   logic [31:0] csr_wdata;

   int fail_count;
   int pending_count;
   int char_count;
   int line_count;

   int items_sent  = 0;
   int cfg_writes  = 0;
   int burst_left  = 0;
   int stall_mode  = 0;
   int stall_left  = 0;
   int cycle_count = 0;

   srec_line_encoder_core u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_data_byte (req_data_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_character (rsp_character),
      .rsp_line_end  (rsp_line_end),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   srec_line_encoder_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_data_byte (req_data_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_character (rsp_character),
      .rsp_line_end  (rsp_line_end),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .char_count    (char_count),
      .line_count    (line_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog
   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   // Receiver stalls: modes of random length, from always ready to mostly stalled
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(16, 96);
      end
      stall_left--;
      case (stall_mode)
         0, 1:    rsp_ready <= 1'b1;
         2:       rsp_ready <= 1'($urandom_range(0, 1));
         default: rsp_ready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // One request transfer; returns at the falling edge after acceptance
   task automatic send_item(input op_type op, input logic [7:0] data);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_operation <= op;
      req_data_byte <= data;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   // Hold off the sender until every owed character has come, then settle
   task automatic wait_drained(input int settle);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   // Writes both registers back to back while the block is idle
   task automatic set_config(input logic [1:0] rtype, input logic [31:0] base);
      wait_drained(4);
      csr_we    <= 1'b1;
      csr_index <= RegRecordType;
      csr_wdata <= 32'(rtype);
      @(negedge clock);
      csr_index <= RegBaseAddress;
      csr_wdata <= base;
      @(negedge clock);
      csr_we    <= 1'b0;
      cfg_writes++;
   endtask

   initial begin
      int          len;
      int          nrec;
      int          random_goal;
      logic [31:0] base;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_operation = OP_START;
      req_data_byte = 8'h00;
      csr_we        = 1'b0;
      csr_index     = RegRecordType;
      csr_wdata     = 32'h0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // S1 at the top of the address space: printed as 16 bits, then wraps to zero
      set_config(TypeS1, 32'hFFFF_FFFF);
      send_item(OP_START, 8'hFF);
      send_item(OP_LAST, 8'hFF);
      send_item(OP_LAST, 8'h00);
      // S3: a full buffer forces a line, then a partial record is dropped by finish
      set_config(TypeS3, 32'hFFFF_FFF8);
      send_item(OP_START, 8'h00);
      for (int i = 0; i < 16; i++) begin
         send_item(OP_DATA, 8'(i * 17));
      end
      send_item(OP_DATA, 8'h5A);
      send_item(OP_FINISH, 8'h5A);
      // S2 terminator, then the unused type code behaving as S1
      set_config(TypeS2, 32'h0012_3456);
      send_item(OP_FINISH, 8'hFF);
      set_config(TypeUnused, 32'h0000_0000);
      send_item(OP_LAST, 8'h7F);
      send_item(OP_FINISH, 8'h01);

      // Random files: optional configure and start, one to four records, optional finish
      random_goal = items_sent + RandomItems;
      while (items_sent < random_goal) begin
         if ($urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 4))
               0:       base = 32'h0000_0000;
               1:       base = 32'hFFFF_FFFF;
               2:       base = 32'hFFFF_FFFF - 32'($urandom_range(0, 40));
               3:       base = {16'($urandom), 16'hFFF0 + 16'($urandom_range(0, 15))};
               default: base = $urandom;
            endcase
            set_config(2'($urandom_range(0, 3)), base);
         end
         if ($urandom_range(0, 5) != 0) begin
            send_item(OP_START, 8'($urandom));
         end
         nrec = $urandom_range(1, 4);
         repeat (nrec) begin
            // mostly short records, some running past the buffer size
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 24)
                                              : $urandom_range(1, 16);
            for (int k = 1; k <= len; k++) begin
               if ($urandom_range(0, 15) == 0) begin
                  send_item(op_type'($urandom_range(0, 3)), 8'($urandom));
               end
               send_item((k == len) ? OP_LAST : OP_DATA, 8'($urandom));
            end
         end
         if ($urandom_range(0, 3) != 0) begin
            if ($urandom_range(0, 2) == 0) begin
               send_item(OP_DATA, 8'($urandom));
            end
            send_item(OP_FINISH, 8'($urandom));
         end
      end

      wait_drained(60);
      $display("Run covered %0d requests over %0d register settings;",
               items_sent, cfg_writes, " %0d lines, %0d chars checked.",
               line_count, char_count);
      $display("Types S1/S2/S3 and the unused code, address wrap, full-buffer lines and dropped tails.");
      if (fail_count == 0 && pending_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

@@ srec_line_encoder_core.f @@
sv/srec_pkg.sv
sv/srec_line_encoder_core.sv
tb/srec_line_encoder_checker.sv
tb/tb_srec_line_encoder_core.sv
